>>> rtl/core/atrp_pkg.sv
// shared types, constants and helpers for the accelerometer tilt cordic pipeline
package atrp_pkg;

  // raw sample and result widths
  localparam int unsigned AccW   = 16;
  localparam int unsigned AngW   = 16;
  // input guard shift: samples are scaled by 2^14 before rotation
  localparam int unsigned GuardW = 14;
  // x/y datapath: 17-bit magnitude, guard bits, cordic gain and sign
  localparam int unsigned XW     = 34;
  // angle accumulator: 32 fraction bits, +-pi plus table sum
  localparam int unsigned ZW     = 36;
  localparam int unsigned TableLen = 24;

  // pi scaled by 2^32
  localparam logic signed [ZW-1:0] PiQ32 = 36'sd13493037705;

  // atan(2^-i) scaled by 2^32
  localparam logic [31:0] AtanQ32 [TableLen] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

  // how a lane's final angle is formed
  typedef enum logic [1:0] {
    LANE_CORDIC = 2'd0,  // rounded accumulator
    LANE_ZERO   = 2'd1,  // sine side zero, cosine side positive
    LANE_PI     = 2'd2,  // sine side zero, cosine side negative
    LANE_UNDEF  = 2'd3   // both sides zero
  } lane_e;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    lane_e                kind;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
  } tilt_t;

  // set up one lane: classify, scale and fold into the right half plane
  function automatic lane_t prep_lane(input logic signed [AccW:0] ys,
                                      input logic signed [AccW:0] xc);
    lane_t                l;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] yss;
    xs  = {{(XW-AccW-1-GuardW){xc[AccW]}}, xc, {GuardW{1'b0}}};
    yss = {{(XW-AccW-1-GuardW){ys[AccW]}}, ys, {GuardW{1'b0}}};
    if (ys == '0) begin
      if (xc == '0) begin
        l.kind = LANE_UNDEF;
      end else if (!xc[AccW]) begin
        l.kind = LANE_ZERO;
      end else begin
        l.kind = LANE_PI;
      end
    end else begin
      l.kind = LANE_CORDIC;
    end
    if (xc[AccW]) begin
      l.z = (ys > 0) ? PiQ32 : -PiQ32;
      l.x = -xs;
      l.y = -yss;
    end else begin
      l.z = '0;
      l.x = xs;
      l.y = yss;
    end
    return l;
  endfunction

endpackage

>>> rtl/core/accel_tilt_roll_pitch.sv
// top level: accelerometer roll and pitch by a pipelined vectoring cordic
// Takes one raw x/y/z accelerometer word and returns roll = atan2(-x, z) and
// pitch = atan2(y, z) in radians, signed with ANGLE_FRAC_BITS fraction bits
// (Q3.13 by default), plus a defined flag per angle that drops when both of its
// components are zero (the angle then reads 0). A sample passes an input cell,
// CORDIC_STAGES rotation cells and an output cell; every cell has its own
// register and handshake, so a new sample is taken every cycle and a stalled
// output only stops the chain once all cells in front of it are full. There is
// no configuration and no state beyond the pipeline.
module accel_tilt_roll_pitch #(
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] acc_x_i,
  input  logic signed [15:0] acc_y_i,
  input  logic signed [15:0] acc_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic               roll_defined_o,
  output logic               pitch_defined_o
);
  import atrp_pkg::*;

  logic  stg_valid [CORDIC_STAGES+1];
  logic  stg_ready [CORDIC_STAGES+1];
  tilt_t stg_data  [CORDIC_STAGES+1];

  // input cell
  atrp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .acc_x_i (acc_x_i),
    .acc_y_i (acc_y_i),
    .acc_z_i (acc_z_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // chain of rotation cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    atrp_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // rounding and output register
  atrp_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (stg_valid[CORDIC_STAGES]),
    .ready_o         (stg_ready[CORDIC_STAGES]),
    .data_i          (stg_data[CORDIC_STAGES]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .roll_angle_o    (roll_angle_o),
    .pitch_angle_o   (pitch_angle_o),
    .roll_defined_o  (roll_defined_o),
    .pitch_defined_o (pitch_defined_o)
  );

endmodule

>>> rtl/core/atrp_prep.sv
// input cell: negates x, scales the axes and folds each lane into the right half plane
module atrp_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [15:0]      acc_x_i,
  input  logic signed [15:0]      acc_y_i,
  input  logic signed [15:0]      acc_z_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output atrp_pkg::tilt_t         data_o
);
  import atrp_pkg::*;

  logic                  valid_q;
  tilt_t                 data_q;
  tilt_t                 data_d;
  logic signed [AccW:0]  neg_x;
  logic signed [AccW:0]  ext_y;
  logic signed [AccW:0]  ext_z;

  // roll = atan2(-x, z), pitch = atan2(y, z)
  always_comb begin
    neg_x        = -{acc_x_i[AccW-1], acc_x_i};
    ext_y        = {acc_y_i[AccW-1], acc_y_i};
    ext_z        = {acc_z_i[AccW-1], acc_z_i};
    data_d.roll  = prep_lane(neg_x, ext_z);
    data_d.pitch = prep_lane(ext_y, ext_z);
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/atrp_cell.sv
// one vectoring cordic iteration for the roll and pitch lanes, with its own register
module atrp_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  atrp_pkg::tilt_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output atrp_pkg::tilt_t data_o
);
  import atrp_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(AtanQ32[STAGE]);

  logic  valid_q;
  tilt_t data_q;
  tilt_t data_d;

  // rotate toward the x axis by atan(2^-STAGE)
  function automatic lane_t rotate(input lane_t l);
    lane_t                r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = l.y >>> STAGE;
    dy = l.x >>> STAGE;
    r.kind = l.kind;
    if (!l.y[XW-1]) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + Atan;
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - Atan;
    end
    return r;
  endfunction

  always_comb begin
    data_d.roll  = rotate(data_i.roll);
    data_d.pitch = rotate(data_i.pitch);
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/atrp_post.sv
// output cell: rounds and clamps the angles, applies the special cases, holds the result word
module atrp_post #(
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  atrp_pkg::tilt_t    data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic               roll_defined_o,
  output logic               pitch_defined_o
);
  import atrp_pkg::*;

  localparam int unsigned          Sh   = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Half = ZW'(1) <<< (Sh - 1);
  localparam logic signed [ZW-1:0] PiQ  = (PiQ32 + Half) >>> Sh;

  logic                   valid_q;
  logic signed [AngW-1:0] roll_q, roll_d;
  logic signed [AngW-1:0] pitch_q, pitch_d;
  logic                   rdef_q, rdef_d;
  logic                   pdef_q, pdef_d;

  // {defined, angle} for one lane
  function automatic logic [AngW:0] finish(input lane_t l);
    logic signed [ZW-1:0] r;
    logic [AngW:0]        res;
    r = (l.z + Half) >>> Sh;
    if (r > PiQ) begin
      r = PiQ;
    end
    if (r < -PiQ) begin
      r = -PiQ;
    end
    unique case (l.kind)
      LANE_CORDIC: res = {1'b1, r[AngW-1:0]};
      LANE_ZERO:   res = {1'b1, {AngW{1'b0}}};
      LANE_PI:     res = {1'b1, PiQ[AngW-1:0]};
      LANE_UNDEF:  res = {1'b0, {AngW{1'b0}}};
      default:     res = {1'b0, {AngW{1'b0}}};
    endcase
    return res;
  endfunction

  always_comb begin
    {rdef_d, roll_d}  = finish(data_i.roll);
    {pdef_d, pitch_d} = finish(data_i.pitch);
  end

  // output register handshake
  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      rdef_q  <= rdef_d;
      pdef_q  <= pdef_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign roll_defined_o  = rdef_q;
  assign pitch_defined_o = pdef_q;

endmodule

>>> rtl/core/atrp_checker.sv
// port-level checks for the tilt pipeline, bound to the top level
module atrp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] pitch_angle_o,
  input logic               roll_defined_o,
  input logic               pitch_defined_o
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roll_angle_o) &&
    $stable(pitch_angle_o) && $stable(roll_defined_o) && $stable(pitch_defined_o))
    else $error("result word changed while stalled");

  // input only backs up when the output is full and stalled
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // undefined roll reads as zero
  a_roll_undef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !roll_defined_o |-> roll_angle_o == '0)
    else $error("undefined roll with nonzero angle");

  // undefined pitch reads as zero
  a_pitch_undef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pitch_defined_o |-> pitch_angle_o == '0)
    else $error("undefined pitch with nonzero angle");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

>>> tb/accel_tilt_roll_pitch_tb.sv
// self-checking testbench for the accelerometer roll and pitch cordic pipeline
`timescale 1ns / 100ps

// one predicted result word
typedef struct {
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic               roll_def;
  logic               pitch_def;
} tilt_word_t;

// predicts roll and pitch for each accepted sample and checks the results in order
class tilt_scoreboard;
  tilt_word_t pending_tilt[$];
  int         mismatches;
  int         frac_bits;
  int         stages;

  function new(int frac, int nstages);
    mismatches = 0;
    frac_bits  = frac;
    stages     = nstages;
  endfunction

  // atan(2^-i) in radians, scaled by 2^32
  function longint atan_step(int i);
    case (i)
      0:  return 64'sd3373259426;
      1:  return 64'sd1991351318;
      2:  return 64'sd1052175346;
      3:  return 64'sd534100635;
      4:  return 64'sd268086748;
      5:  return 64'sd134174063;
      6:  return 64'sd67103403;
      7:  return 64'sd33553749;
      8:  return 64'sd16777131;
      9:  return 64'sd8388597;
      10: return 64'sd4194303;
      11: return 64'sd2097152;
      12: return 64'sd1048576;
      13: return 64'sd524288;
      14: return 64'sd262144;
      15: return 64'sd131072;
      16: return 64'sd65536;
      17: return 64'sd32768;
      18: return 64'sd16384;
      19: return 64'sd8192;
      20: return 64'sd4096;
      21: return 64'sd2048;
      22: return 64'sd1024;
      default: return 64'sd512;
    endcase
  endfunction

  // round a 32-fraction-bit angle to the output precision
  function longint round_angle(longint a);
    int sh;
    sh = 32 - frac_bits;
    return (a + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // atan2(sine side, cosine side) by vectoring cordic
  function longint tilt_atan2(longint ys, longint xc, output logic defined);
    longint pi_q32;
    longint pi_r;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint r;
    pi_q32  = 64'sd13493037705;
    pi_r    = round_angle(pi_q32);
    defined = 1'b1;
    // on an axis: zero, pi or undefined
    if (ys == 0) begin
      if (xc == 0) begin
        defined = 1'b0;
        return 0;
      end
      return (xc > 0) ? 64'sd0 : pi_r;
    end
    x = xc * 16384;
    y = ys * 16384;
    z = 0;
    // fold the left half plane over
    if (x < 0) begin
      z = (y > 0) ? pi_q32 : -pi_q32;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < stages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end
    end
    r = round_angle(z);
    if (r > pi_r) r = pi_r;
    if (r < -pi_r) r = -pi_r;
    return r;
  endfunction

  // accepted sample: predict its word
  function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az);
    tilt_word_t w;
    longint     r;
    longint     p;
    logic       rd;
    logic       pd;
    r = tilt_atan2(-longint'(ax), longint'(az), rd);
    p = tilt_atan2(longint'(ay), longint'(az), pd);
    w.roll      = r[15:0];
    w.pitch     = p[15:0];
    w.roll_def  = rd;
    w.pitch_def = pd;
    pending_tilt.push_back(w);
  endfunction

  // accepted result word: compare with the oldest prediction
  function void check_word(logic signed [15:0] roll, logic signed [15:0] pitch,
                           logic roll_def, logic pitch_def);
    tilt_word_t w;
    if (pending_tilt.size() == 0) begin
      $error("result word with no sample outstanding: roll %0d pitch %0d", roll, pitch);
      mismatches++;
      return;
    end
    w = pending_tilt.pop_front();
    if (roll !== w.roll) begin
      $error("roll_angle: expected %0d, got %0d", w.roll, roll);
      mismatches++;
    end
    if (pitch !== w.pitch) begin
      $error("pitch_angle: expected %0d, got %0d", w.pitch, pitch);
      mismatches++;
    end
    if (roll_def !== w.roll_def) begin
      $error("roll_defined: expected %0b, got %0b", w.roll_def, roll_def);
      mismatches++;
    end
    if (pitch_def !== w.pitch_def) begin
      $error("pitch_defined: expected %0b, got %0b", w.pitch_def, pitch_def);
      mismatches++;
    end
  endfunction

  function int pending();
    return pending_tilt.size();
  endfunction
endclass

module accel_tilt_roll_pitch_tb;
  localparam int unsigned Stages    = 16;
  localparam int unsigned FracBits  = 13;
  localparam int unsigned NumRandom = 1180;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainWait = Stages + 8;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic               roll_defined;
  logic               pitch_defined;

  tilt_scoreboard sb;
  bit             no_idle;
  int unsigned    idle_cycles;

  accel_tilt_roll_pitch #(
    .CORDIC_STAGES  (Stages),
    .ANGLE_FRAC_BITS(FracBits)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .acc_x_i        (acc_x),
    .acc_y_i        (acc_y),
    .acc_z_i        (acc_z),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .roll_angle_o   (roll_angle),
    .pitch_angle_o  (pitch_angle),
    .roll_defined_o (roll_defined),
    .pitch_defined_o(pitch_defined)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // gap before a word, none during burst stretches
  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // one axis value of a given flavor
  function automatic logic signed [15:0] draw_axis();
    int unsigned style;
    style = $urandom_range(0, 9);
    if (style <= 4) return 16'($urandom);
    if (style <= 6) return 16'(int'($urandom_range(0, 32)) - 16);
    if (style == 7) return 16'sd0;
    case ($urandom_range(0, 5))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return -16'sd32767;
      default: return 16'sd0;
    endcase
  endfunction

  // present one sample word and hold it until taken; starts and ends at a falling edge
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    acc_x    <= x;
    acc_y    <= y;
    acc_z    <= z;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // result side: random stall before each word
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // handshake monitor and idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_sample(acc_x, acc_y, acc_z);
      if (out_valid && out_ready) begin
        sb.check_word(roll_angle, pitch_angle, roll_defined, pitch_defined);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    sb          = new(FracBits, Stages);
    no_idle     = 1'b0;
    idle_cycles = 0;
    in_valid    = 1'b0;
    acc_x       = '0;
    acc_y       = '0;
    acc_z       = '0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all zero: both angles undefined
    send_sample(16'sd0, 16'sd0, 16'sd0);
    // roll undefined, pitch straight up
    send_sample(16'sd0, 16'sd5, 16'sd0);
    // pitch undefined, roll straight down
    send_sample(16'sd7, 16'sd0, 16'sd0);
    // sine sides zero, cosine positive: exact zero
    send_sample(16'sd0, 16'sd0, 16'sd100);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    // sine sides zero, cosine negative: exact +pi
    send_sample(16'sd0, 16'sd0, -16'sd100);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    // just off the negative cosine axis: clamp toward +pi and -pi
    send_sample(-16'sd1, 16'sd1, -16'sd32768);
    send_sample(16'sd1, -16'sd1, -16'sd32768);
    send_sample(-16'sd1, 16'sd1, -16'sd1);
    send_sample(16'sd1, -16'sd1, -16'sd1);
    // negated most-negative x needs the extra bit
    send_sample(-16'sd32768, 16'sd32767, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, 16'sd0);
    // corners of the field ranges
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768, 16'sd32767);
    send_sample(16'sd32767, 16'sd32767, -16'sd32768);
    send_sample(16'sd1000, -16'sd1000, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(16'sd100, -16'sd100, -16'sd1);
    send_sample(-16'sd32768, 16'sd32767, 16'sd1);

    // random words, with burst stretches that have no idling
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_sample(draw_axis(), draw_axis(), draw_axis());
    end
    no_idle  = 1'b0;
    in_valid <= 1'b0;

    // drain the pipeline
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
